// File: rtl/floored_max_heap_tracker_defines.svh
// Assertion macros shared by the checker.
`ifndef FLOORED_MAX_HEAP_TRACKER_DEFINES_SVH
`define FLOORED_MAX_HEAP_TRACKER_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define FMH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define FMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fmh_pkg.sv
package fmh_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_REMOVE  = 2'd1;
  localparam logic [1:0] ACT_REPLACE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [0:0] REG_FLOOR = 1'b0;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
    logic signed [31:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] maximum;
    logic [6:0]         count;
    logic [1:0]         status;
  } out_item_t;

  // Datapath commands issued by the controller states.
  typedef enum logic [3:0] {
    CMD_IDLE   = 4'd0,
    CMD_LOAD   = 4'd1,  // capture the beat
    CMD_SRCH   = 4'd2,  // issue search read at idx
    CMD_SCMP   = 4'd3,  // compare search data
    CMD_LIFTR  = 4'd4,  // read parent of hole
    CMD_LIFTW  = 4'd5,  // write parent into hole, hole goes up
    CMD_LASTR  = 4'd6,  // read last entry, decrement count
    CMD_DNR    = 4'd7,  // read left child
    CMD_DNR2   = 4'd8,  // capture left, read right child
    CMD_DNW    = 4'd9,  // decide and write
    CMD_INSB   = 4'd10, // begin insert
    CMD_UPR    = 4'd11, // read parent
    CMD_UPW    = 4'd12, // compare and write
    CMD_TOPR   = 4'd13, // read root
    CMD_DONE   = 4'd14  // capture result
  } cmd_t;

  typedef struct packed {
    logic       below_floor;  // current operand at or below floor
    logic       ins_below;    // value to be inserted at or below floor
    logic       full;
    logic       search_end;   // search index reached count
    logic       hit;
    logic       at_root;      // hole index is zero
    logic       no_kid;       // left child beyond count
    logic       has_right;
    logic       move;         // compare result of the step
    logic       replace;
    logic       insert_only;
    logic       valid_act;
  } status_t;

endpackage

// File: rtl/fmh_ram.sv
module fmh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fmh_datapath.sv
module fmh_datapath #(
  parameter int unsigned CAPACITY = fmh_pkg::CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fmh_pkg::cmd_t         cmd,
  input  fmh_pkg::in_item_t     in_item,
  input  logic signed [31:0]    floor_value,
  output fmh_pkg::status_t      stat,
  output fmh_pkg::out_item_t    result
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  fmh_pkg::in_item_t item;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] idx;        // search index / hole / insert position
  logic signed [31:0] opnd;  // value being removed or inserted
  logic signed [31:0] last;
  logic signed [31:0] lval;  // left child value
  logic [1:0] st;
  logic phase_ins;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  fmh_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [CW-1:0] parent;
  logic [CW:0]   left_w;
  logic [CW-1:0] cnt_m1;
  logic signed [31:0] rs;
  logic signed [31:0] ins_val;
  logic right_big;

  assign parent = (idx - 1'b1) >> 1;
  assign left_w = {idx, 1'b1};
  assign cnt_m1 = entry_count - 1'b1;
  assign rs = $signed(rdata);
  assign right_big = lval < rs;
  assign ins_val = (item.action == fmh_pkg::ACT_REPLACE) ? item.new_value : item.value;

  always_comb begin
    we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rdata;
    raddr = idx[AW-1:0];
    unique case (cmd)
      fmh_pkg::CMD_LIFTR: raddr = parent[AW-1:0];
      fmh_pkg::CMD_LIFTW: we = 1'b1;
      fmh_pkg::CMD_LASTR: raddr = cnt_m1[AW-1:0];
      fmh_pkg::CMD_DNR:   raddr = left_w[AW-1:0];
      fmh_pkg::CMD_DNR2:  raddr = AW'(left_w + 1'b1);
      fmh_pkg::CMD_DNW: begin
        we = 1'b1;
        if (stat.move) begin
          wdata = (stat.has_right && right_big) ? rdata : lval;
        end else begin
          wdata = last;
        end
      end
      fmh_pkg::CMD_UPR:  raddr = parent[AW-1:0];
      fmh_pkg::CMD_UPW: begin
        we = 1'b1;
        wdata = stat.move ? rdata : opnd;
      end
      fmh_pkg::CMD_TOPR: raddr = '0;
      default: ;
    endcase
  end

  // The sift-down step belongs to the remove phase and the sift-up step to the
  // insert phase, so the phase flag selects which compare is reported.
  always_comb begin
    stat = '0;
    stat.below_floor = opnd <= floor_value;
    stat.ins_below = ins_val <= floor_value;
    stat.full = entry_count >= CW'(CAPACITY);
    stat.search_end = idx >= entry_count;
    stat.hit = rs == opnd;
    stat.at_root = idx == '0;
    stat.no_kid = left_w >= {1'b0, entry_count};
    stat.has_right = (left_w + 1'b1) < {1'b0, entry_count};
    stat.replace = item.action == fmh_pkg::ACT_REPLACE;
    stat.insert_only = item.action == fmh_pkg::ACT_INSERT;
    stat.valid_act = item.action <= fmh_pkg::ACT_REPLACE;
    if (phase_ins) begin
      stat.move = !stat.at_root && (rs < opnd);
    end else begin
      stat.move = !stat.no_kid && (last < ((stat.has_right && right_big) ? rs : lval));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      unique case (cmd)
        fmh_pkg::CMD_LASTR: entry_count <= cnt_m1;
        fmh_pkg::CMD_INSB: begin
          if (!stat.ins_below && !stat.full) begin
            entry_count <= entry_count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      fmh_pkg::CMD_LOAD: begin
        item <= in_item;
        opnd <= in_item.value;
        idx <= '0;
        st <= fmh_pkg::ST_OK;
        phase_ins <= in_item.action == fmh_pkg::ACT_INSERT;
      end
      fmh_pkg::CMD_SCMP: begin
        if (!stat.hit) begin
          idx <= idx + 1'b1;
        end
      end
      fmh_pkg::CMD_LIFTW: idx <= parent;
      fmh_pkg::CMD_LASTR: idx <= '0;
      fmh_pkg::CMD_DNR: last <= (idx == '0 && !phase_ins) ? rs : last;
      fmh_pkg::CMD_DNR2: lval <= rs;
      fmh_pkg::CMD_DNW: begin
        if (stat.move) begin
          idx <= (stat.has_right && right_big) ? CW'(left_w + 1'b1) : CW'(left_w);
        end
      end
      fmh_pkg::CMD_INSB: begin
        opnd <= ins_val;
        phase_ins <= 1'b1;
        idx <= entry_count;
      end
      fmh_pkg::CMD_UPW: if (stat.move) idx <= parent;
      default: ;
    endcase
    // Status tracking: not found wins over full.
    if (cmd == fmh_pkg::CMD_SCMP && stat.search_end) begin
      st <= fmh_pkg::ST_NOT_FOUND;
    end
    if (cmd == fmh_pkg::CMD_INSB && !stat.ins_below && stat.full &&
        st == fmh_pkg::ST_OK) begin
      st <= fmh_pkg::ST_FULL;
    end
    if (cmd == fmh_pkg::CMD_DONE) begin
      result.maximum <= (entry_count == '0) ? floor_value : rs;
      result.count <= 7'(entry_count);
      result.status <= st;
    end
  end

endmodule

// File: rtl/fmh_ctrl.sv
module fmh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fmh_pkg::status_t  stat,
  output fmh_pkg::cmd_t     cmd
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_CHK   = 15'b000000000000010,
    S_SRCH  = 15'b000000000000100,
    S_SCMP  = 15'b000000000001000,
    S_LIFTR = 15'b000000000010000,
    S_LIFTW = 15'b000000000100000,
    S_LASTR = 15'b000000001000000,
    S_DNR   = 15'b000000010000000,
    S_DNR2  = 15'b000000100000000,
    S_DNW   = 15'b000001000000000,
    S_INSB  = 15'b000010000000000,
    S_UPR   = 15'b000100000000000,
    S_UPW   = 15'b001000000000000,
    S_TOPR  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  state_t state, state_next;
  logic out_valid_next;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cmd = fmh_pkg::CMD_IDLE;
    unique case (state)
      S_IDLE: if (in_valid && in_ready) begin
        cmd = fmh_pkg::CMD_LOAD;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (!stat.valid_act) state_next = S_TOPR;
        else if (stat.insert_only) state_next = S_INSB;
        else if (stat.below_floor) state_next = stat.replace ? S_INSB : S_TOPR;
        else state_next = S_SRCH;
      end
      S_SRCH: begin
        cmd = fmh_pkg::CMD_SRCH;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        cmd = fmh_pkg::CMD_SCMP;
        if (stat.search_end) state_next = stat.replace ? S_INSB : S_TOPR;
        else if (stat.hit) state_next = S_LIFTR;
        else state_next = S_SRCH;
      end
      S_LIFTR: begin
        if (stat.at_root) begin
          state_next = S_LASTR;
        end else begin
          cmd = fmh_pkg::CMD_LIFTR;
          state_next = S_LIFTW;
        end
      end
      S_LIFTW: begin
        cmd = fmh_pkg::CMD_LIFTW;
        state_next = S_LIFTR;
      end
      S_LASTR: begin
        cmd = fmh_pkg::CMD_LASTR;
        state_next = S_DNR;
      end
      S_DNR: begin
        cmd = fmh_pkg::CMD_DNR;
        state_next = S_DNR2;
      end
      S_DNR2: begin
        cmd = fmh_pkg::CMD_DNR2;
        state_next = S_DNW;
      end
      S_DNW: begin
        cmd = fmh_pkg::CMD_DNW;
        if (stat.move) state_next = S_DNR;
        else state_next = stat.replace ? S_INSB : S_TOPR;
      end
      S_INSB: begin
        cmd = fmh_pkg::CMD_INSB;
        if (stat.ins_below || stat.full) state_next = S_TOPR;
        else state_next = S_UPR;
      end
      S_UPR: begin
        cmd = fmh_pkg::CMD_UPR;
        state_next = S_UPW;
      end
      S_UPW: begin
        cmd = fmh_pkg::CMD_UPW;
        if (stat.move) state_next = S_UPR;
        else state_next = S_TOPR;
      end
      S_TOPR: begin
        cmd = fmh_pkg::CMD_TOPR;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd = fmh_pkg::CMD_DONE;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (state == S_DONE) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/floored_max_heap_tracker.sv
// Floored max-heap tracker.
// The input channel (in_valid, in_ready, in_data) carries one action beat:
// insert, remove or replace of a signed 32-bit value. Every accepted beat
// produces exactly one result beat on the output channel (out_valid,
// out_ready, out_data) holding the current maximum, the count and a status.
// Values at or below floor_value, written over the APB-style port, are
// ignored, and the floor is reported as the maximum while the heap is empty.
// The heap lives in a registered-read RAM, so every search, lift and sift
// step issues its read in one state and uses the data in a later state.
// The next beat is not accepted before the result beat is taken.
// The result sits in an output register; while the receiver stalls the
// block holds it and accepts no new beat until it is taken.
// Reset clears the count, the floor and the handshake state; RAM contents
// are left undefined, and nothing stored beyond the count reaches a result.
module floored_max_heap_tracker #(
  parameter int unsigned CAPACITY = fmh_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fmh_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fmh_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  fmh_pkg::cmd_t    cmd;
  fmh_pkg::status_t stat;
  logic signed [31:0] floor_value;

  assign pready = 1'b1;
  assign prdata = (paddr[1:1] == fmh_pkg::REG_FLOOR) ? floor_value : '0;

  // Only one register exists; writes with paddr[1] set are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_value <= '0;
    end else if (psel && penable && pwrite && paddr[1:1] == fmh_pkg::REG_FLOOR) begin
      floor_value <= pwdata;
    end
  end

  fmh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  fmh_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_item(in_data),
    .floor_value(floor_value), .stat(stat), .result(out_data)
  );

endmodule

// File: rtl/fmh_checker.sv
`include "floored_max_heap_tracker_defines.svh"

module fmh_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input fmh_pkg::out_item_t out_data
);

  `FMH_ASSERT_NEXT(a_accept_blocks, clk, rst, in_valid && in_ready, !in_ready, "busy after accept")
  `FMH_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
  `FMH_ASSERT_SAME(a_count_range, clk, rst, out_valid, out_data.count <= 7'd64, "count too large")
  `FMH_ASSERT_SAME(a_no_in_while_out, clk, rst, out_valid && !out_ready, !in_ready, "accept while stalled")

endmodule

bind floored_max_heap_tracker fmh_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps

// Testbench for the floored max-heap tracker.
// An initial block fills a queue of action beats; a clocked driver presents
// them with random gaps, and a clocked monitor takes result beats with random
// stalls. A behavioral heap predicts each result when its action beat is
// accepted, and the monitor compares every result beat with the oldest
// prediction. The floor register is written between phases while idle.
module testbench;

  localparam int HEAP_SIZE = fmh_pkg::CAPACITY_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  fmh_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fmh_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  floored_max_heap_tracker dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: our own copy of the heap, its fill level and the floor.
  logic signed [31:0] heap_vals [HEAP_SIZE];
  int heap_fill;
  logic signed [31:0] floor_now;

  fmh_pkg::out_item_t expected_results[$];
  fmh_pkg::in_item_t pending_actions[$];
  int errors;

  // Shadow of what the testbench believes is stored, used to pick values that
  // actually hit during remove and replace.
  logic signed [31:0] stored_vals[$];

  function automatic logic [1:0] heap_push(logic signed [31:0] v);
    int pos;
    int up;
    if (v <= floor_now) return fmh_pkg::ST_OK;
    if (heap_fill >= HEAP_SIZE) return fmh_pkg::ST_FULL;
    pos = heap_fill;
    heap_fill++;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!(heap_vals[up] < v)) break;
      heap_vals[pos] = heap_vals[up];
      pos = up;
    end
    heap_vals[pos] = v;
    return fmh_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] heap_pull(logic signed [31:0] v);
    int found;
    int hole;
    int kid;
    logic signed [31:0] last;
    if (v <= floor_now) return fmh_pkg::ST_OK;
    found = -1;
    for (int i = 0; i < heap_fill; i++) begin
      if (heap_vals[i] == v) begin
        found = i;
        break;
      end
    end
    if (found < 0) return fmh_pkg::ST_NOT_FOUND;
    // Lift the hit to the root by shifting its ancestors down one level.
    hole = found;
    while (hole > 0) begin
      heap_vals[hole] = heap_vals[(hole - 1) / 2];
      hole = (hole - 1) / 2;
    end
    heap_fill--;
    last = heap_vals[heap_fill];
    hole = 0;
    forever begin
      kid = 2 * hole + 1;
      if (kid >= heap_fill) break;
      if (kid + 1 < heap_fill && heap_vals[kid] < heap_vals[kid + 1]) kid++;
      if (last < heap_vals[kid]) begin
        heap_vals[hole] = heap_vals[kid];
        hole = kid;
      end else begin
        break;
      end
    end
    heap_vals[hole] = last;
    return fmh_pkg::ST_OK;
  endfunction

  function automatic fmh_pkg::out_item_t heap_apply(fmh_pkg::in_item_t a);
    fmh_pkg::out_item_t r;
    logic [1:0] rs;
    logic [1:0] is;
    r.status = fmh_pkg::ST_OK;
    case (a.action)
      fmh_pkg::ACT_INSERT: begin
        r.status = heap_push(a.value);
      end
      fmh_pkg::ACT_REMOVE: begin
        r.status = heap_pull(a.value);
      end
      fmh_pkg::ACT_REPLACE: begin
        rs = heap_pull(a.value);
        is = heap_push(a.new_value);
        r.status = (rs != fmh_pkg::ST_OK) ? rs : is;
      end
      default: begin
      end
    endcase
    r.maximum = (heap_fill == 0) ? floor_now : heap_vals[0];
    r.count = 7'(heap_fill);
    return r;
  endfunction

  // Driver: before each beat valid stays low while a random gap counter runs
  // down. When the gap drawn at an accept is zero, the next beat is loaded in
  // the same step, so valid simply stays high for a back-to-back beat.
  int in_gap;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(heap_apply(in_data));
        in_gap = $urandom_range(0, 9);
        if (in_gap == 0 && pending_actions.size() > 0) begin
          in_data <= pending_actions.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_actions.size() > 0) begin
          in_data <= pending_actions.pop_front();
          in_valid <= 1'b1;
          in_gap = $urandom_range(0, 9);
        end
      end
    end
  end

  // Monitor: after each result beat, ready stays low while a random stall counter runs down.
  int out_stall;
  fmh_pkg::out_item_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.maximum !== want.maximum) begin
            $display("%0t: maximum expected %0d actual %0d", $time,
                     want.maximum, out_data.maximum);
            errors++;
          end
          if (out_data.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time,
                     want.count, out_data.count);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_data.status);
            errors++;
          end
        end
        out_stall = $urandom_range(0, 9);
        out_ready <= (out_stall == 0);
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= (out_stall == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // The floor write is a setup phase and then an access phase.
  task automatic write_floor(logic signed [31:0] f);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {fmh_pkg::REG_FLOOR, 1'b0};
    pwdata <= f;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    floor_now = f;
  endtask

  // Waits until every queued beat has been sent and answered. The check runs
  // at the falling edge, after the clocked blocks have settled; each beat has
  // a result, so nothing is in flight once the queue of predictions is empty.
  task automatic drain();
    while (pending_actions.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    return $signed($urandom());
  endfunction

  function automatic void queue_action(logic [1:0] act, logic signed [31:0] v,
                                       logic signed [31:0] nv);
    fmh_pkg::in_item_t a;
    a.action = act;
    a.value = v;
    a.new_value = nv;
    pending_actions.push_back(a);
  endfunction

  // A value above the floor, drawn mostly from a narrow band so that
  // duplicates and hits are common.
  function automatic logic signed [31:0] pick_above(logic signed [31:0] f);
    logic signed [31:0] v;
    if ($urandom_range(0, 3) == 0) v = rand_word();
    else v = f + $signed(32'($urandom_range(1, 200)));
    if (v <= f) v = 32'sh7fffffff;
    return v;
  endfunction

  // Random phase: fills up, churns around the top, then drains, with noise.
  task automatic random_phase(int n, logic signed [31:0] f);
    int k;
    logic signed [31:0] v;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45 && stored_vals.size() > 0 && i > n / 2) begin
        v = stored_vals[$urandom_range(0, stored_vals.size() - 1)];
        queue_action(fmh_pkg::ACT_REMOVE, v, rand_word());
      end else if (k < 45) begin
        queue_action(fmh_pkg::ACT_INSERT, pick_above(f), rand_word());
        stored_vals.push_back(pending_actions[$].value);
      end else if (k < 75 && stored_vals.size() > 0) begin
        v = stored_vals[$urandom_range(0, stored_vals.size() - 1)];
        queue_action(fmh_pkg::ACT_REPLACE, v, pick_above(f));
        stored_vals.push_back(pending_actions[$].new_value);
      end else if (k < 95) begin
        queue_action(2'($urandom_range(0, 3)), rand_word(), rand_word());
      end else begin
        queue_action(fmh_pkg::ACT_REMOVE, pick_above(f), rand_word());
      end
    end
  endtask

  initial begin
    errors = 0;
    heap_fill = 0;
    floor_now = 0;
    in_gap = 0;
    out_stall = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the reset floor of zero.
    queue_action(fmh_pkg::ACT_REMOVE, 32'sd5, 32'sd0);          // not found on empty
    queue_action(fmh_pkg::ACT_INSERT, 32'sd0, 32'sd0);          // at floor, ignored
    queue_action(fmh_pkg::ACT_INSERT, 32'sh80000000, 32'sd0);   // below floor
    queue_action(fmh_pkg::ACT_INSERT, 32'sh7fffffff, 32'sd0);
    queue_action(fmh_pkg::ACT_INSERT, 32'sd1, 32'sd0);
    queue_action(fmh_pkg::ACT_INSERT, 32'sd1, 32'sd0);
    queue_action(fmh_pkg::ACT_INSERT, 32'sd50, 32'sd0);
    queue_action(fmh_pkg::ACT_REMOVE, 32'sh7fffffff, 32'sd0);   // removing the largest
    queue_action(fmh_pkg::ACT_REMOVE, 32'sd1, 32'sd0);          // duplicate
    queue_action(fmh_pkg::ACT_REMOVE, -32'sd7, 32'sd0);         // below floor
    queue_action(fmh_pkg::ACT_REPLACE, 32'sd50, 32'sd60);
    queue_action(fmh_pkg::ACT_REPLACE, 32'sd99, 32'sd70);       // remove misses
    queue_action(fmh_pkg::ACT_REPLACE, 32'sd60, -32'sd1);       // insert below floor
    queue_action(2'd3, 32'sh7fffffff, 32'sh80000000);           // unused action code
    queue_action(fmh_pkg::ACT_REPLACE, 32'sh80000000, 32'sh7fffffff);
    for (int i = 0; i < 66; i++)                                 // overfill
      queue_action(fmh_pkg::ACT_INSERT, 32'(i + 2), 32'd0);
    queue_action(fmh_pkg::ACT_REPLACE, 32'sd1234, 32'sd9);      // both faults
    queue_action(fmh_pkg::ACT_REPLACE, 32'sd10, 32'sd11);       // ok while full
    queue_action(fmh_pkg::ACT_REMOVE, 32'sd2, 32'sd0);
    queue_action(fmh_pkg::ACT_REPLACE, 32'sd3, 32'sd4);
    drain();

    // Raise the floor while the heap holds entries; stored values stay.
    write_floor(32'sh7fffffff);
    queue_action(fmh_pkg::ACT_INSERT, 32'sh7fffffff, 32'sd0);
    queue_action(fmh_pkg::ACT_REMOVE, 32'sd40, 32'sd0);
    drain();

    // Lowest floor: remove each value 0..69 and the largest once; duplicates stay.
    write_floor(32'sh80000000);
    for (int i = 0; i < 70; i++)
      queue_action(fmh_pkg::ACT_REMOVE, 32'(i), 32'sd0);
    queue_action(fmh_pkg::ACT_REMOVE, 32'sh7fffffff, 32'sd0);
    queue_action(fmh_pkg::ACT_REMOVE, 32'sh80000001, 32'sd0);
    drain();

    stored_vals.delete();
    random_phase(150, 32'sh80000000);
    drain();
    write_floor(-32'sd1000);
    random_phase(100, -32'sd1000);
    drain();
    write_floor(32'sd0);
    random_phase(100, 32'sd0);
    drain();

    repeat (300) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

endmodule
